>>> rtl/tdpc_pkg.sv
// ============================================================================
// tdpc_pkg
// Shared widths, types and sequencer states for the trial-division prime
// counter.
// ============================================================================
package tdpc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int COUNT_BITS = 20;

    // Remainder unit: quotient bits retired per cycle and cycles per divisor
    localparam int REM_STEPS  = 4;
    localparam int REM_CYCLES = (VALUE_BITS + REM_STEPS - 1) / REM_STEPS;
    localparam int PAD_BITS   = REM_CYCLES * REM_STEPS;
    localparam int REM_CNT_W  = $clog2(REM_CYCLES + 1);

    // Divisor never exceeds 2^ceil(VALUE_BITS/2); its square stays below 2^(VALUE_BITS+2)
    localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS    = VALUE_BITS + 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } state_t;

    // Status from the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

    // Finished test handed from the sequencer to the output stage
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
        logic                  prime;
        logic                  first;
    } fin_t;

endpackage

>>> rtl/trial_division_prime_counter.sv
// ============================================================================
// trial_division_prime_counter
// Tests a stream of unsigned values for primality by trial division and keeps
// a saturating running count of primes.
// ============================================================================
//
// Usage:
//   Input channel (in_valid / in_stall, value, first): one value per transfer.
//   in_stall is low only while the sequencer is idle; it rises for the whole
//   test. Set first to restart the prime count with that item.
//   Output channel (out_valid / out_stall, value_out, is_prime, prime_count):
//   one result per input transfer, in order. The result sits in an output
//   register, so the next value is taken while a result waits on out_stall.
//   A stalled result holds until it is taken; a finished test then waits in
//   the sequencer and holds further input.
//   Timing: every divisor d with d*d <= value costs one bound check plus
//   one pass of the single remainder unit (four quotient bits a cycle).
//   Values below four skip the remainder unit. Composites stop at their
//   smallest factor.
//   Reset: asynchronous, active low; clears the sequencer, the output valid
//   and the prime count. No clearing pass is needed.
//
module trial_division_prime_counter
    import tdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  first,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  is_prime,
    output logic [COUNT_BITS-1:0] prime_count
);

    fin_t                  fin;
    logic                  slot_free;
    logic                  take;
    logic [COUNT_BITS-1:0] base;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [VALUE_BITS-1:0] value_out_reg;
    logic                  is_prime_reg;

    // Output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !out_stall;
    assign take      = fin.valid && slot_free;

    tdpc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .first     (first),
        .res_ready (slot_free),
        .fin       (fin)
    );

    // Restart from zero on first, then add this prime unless already saturated
    always_comb
    begin
        base       = fin.first ? '0 : count_reg;
        count_next = count_reg;
        if (take)
        begin
            count_next = (fin.prime && base != COUNT_MAX) ? base + 1'b1 : base;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Load the result payload only on a transfer from the sequencer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_out_reg <= fin.value;
            is_prime_reg  <= fin.prime;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_out   = value_out_reg;
    assign is_prime    = is_prime_reg;
    assign prime_count = count_reg;

endmodule

>>> rtl/tdpc_rem_unit.sv
// ============================================================================
// tdpc_rem_unit
// Iterative restoring remainder unit: several compare-and-subtract steps per
// cycle, reports whether the remainder of value by divisor is zero.
// ============================================================================
module tdpc_rem_unit
    import tdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]   divisor,
    output rem_status_t           status
);

    logic [REM_CNT_W-1:0] cnt_reg;
    logic [REM_CNT_W-1:0] cnt_next;
    logic [PAD_BITS-1:0]  dvd_reg;
    logic [PAD_BITS-1:0]  dvd_next;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [DIV_BITS-1:0]  rem_next;
    logic [DIV_BITS-1:0]  dsr_reg;
    logic [DIV_BITS-1:0]  dsr_next;
    logic [DIV_BITS-1:0]  rem_step;

    // Retire REM_STEPS dividend bits, most significant first
    always_comb
    begin
        logic [DIV_BITS:0] r;
        logic [DIV_BITS:0] t;
        r = {1'b0, rem_reg};
        for (int i = 0; i < REM_STEPS; i++)
        begin
            t = {r[DIV_BITS-1:0], dvd_reg[PAD_BITS-1-i]};
            if (t >= {1'b0, dsr_reg})
            begin
                t = t - {1'b0, dsr_reg};
            end
            r = t;
        end
        rem_step = r[DIV_BITS-1:0];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = REM_CNT_W'(REM_CYCLES);
            dvd_next = PAD_BITS'(dividend);
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = dvd_reg << REM_STEPS;
            rem_next = rem_step;
        end
    end

    assign status.done = (cnt_reg == REM_CNT_W'(1));
    assign status.zero = (rem_step == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

>>> rtl/tdpc_seq.sv
// ============================================================================
// tdpc_seq
// Sequencer for one primality test: walks divisors from two upward while the
// divisor squared does not exceed the value, driving the remainder unit.
// ============================================================================
module tdpc_seq
    import tdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  first,
    input  logic                  res_ready,
    output fin_t                  fin
);

    state_t                state_reg;
    state_t                state_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  first_reg;
    logic                  first_next;
    logic                  prime_reg;
    logic                  prime_next;
    logic [DIV_BITS-1:0]   div_reg;
    logic [DIV_BITS-1:0]   div_next;
    logic [SQ_BITS-1:0]    sq_reg;
    logic [SQ_BITS-1:0]    sq_next;

    logic                  accept;
    logic                  too_small;
    logic                  past_root;
    logic                  rem_start;
    rem_status_t           rem_status;

    assign accept    = in_valid && !in_stall;
    assign too_small = (value_reg < VALUE_BITS'(2));
    assign past_root = (sq_reg > SQ_BITS'(value_reg));

    tdpc_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (value_reg),
        .divisor  (div_reg),
        .status   (rem_status)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (too_small || past_root)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_status.done)
                begin
                    state_next = rem_status.zero ? S_FINISH : S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        in_stall   = 1'b1;
        rem_start  = 1'b0;
        value_next = value_reg;
        first_next = first_reg;
        prime_next = prime_reg;
        div_next   = div_reg;
        sq_next    = sq_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                value_next = value;
                first_next = first;
                div_next   = DIV_BITS'(2);
                sq_next    = SQ_BITS'(4);
            end
            S_CHECK:
            begin
                prime_next = !too_small;
                rem_start  = !(too_small || past_root);
            end
            S_DIV:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.zero)
                    begin
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        div_next = div_reg + 1'b1;
                        sq_next  = sq_reg + SQ_BITS'({div_reg, 1'b0}) + SQ_BITS'(1);
                    end
                end
            end
            S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign fin.valid = (state_reg == S_FINISH);
    assign fin.value = value_reg;
    assign fin.prime = prime_reg;
    assign fin.first = first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept || state_reg != S_IDLE)
        begin
            value_reg <= value_next;
            first_reg <= first_next;
        end
        prime_reg <= prime_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
    end

endmodule

>>> rtl/tdpc_check.sv
// ============================================================================
// tdpc_check
// Port-level checks for the trial-division prime counter, bound to the top.
// ============================================================================
module tdpc_check
    import tdpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  first,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [VALUE_BITS-1:0] value_out,
    input  logic                  is_prime,
    input  logic [COUNT_BITS-1:0] prime_count
);

    // Busy for the test once a value is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after transfer");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_out)
            && $stable(is_prime) && $stable(prime_count))
        else $error("stalled result changed");

    // Zero and one are never prime
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_out < VALUE_BITS'(2) |-> !is_prime)
        else $error("value below two flagged prime");

    // Even values above two are composite
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_out > VALUE_BITS'(2) && !value_out[0] |-> !is_prime)
        else $error("even value flagged prime");

    // A prime result always counts at least itself
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_prime |-> prime_count != '0)
        else $error("prime result with zero count");

endmodule

bind trial_division_prime_counter tdpc_check u_tdpc_check (.*);
